FILE: rtl/brcm_pkg.sv
// ----------------------------------------------------------------------------
// brcm_pkg: shared definitions for the banked rom/ram cartridge mapper
// function codes, bank geometry defaults and the pipeline stage record
// ----------------------------------------------------------------------------
package brcm_pkg;

  // geometry
  localparam int BANK_BYTES        = 16384;
  localparam int HALF_OFFSET_W     = 13;
  localparam int RAM_BANKS_DEF     = 32;
  localparam int ROM_BANKS_MAX_DEF = 16;
  localparam int ROM_LOAD_ADDR_W   = 18;
  localparam int COUNT_W           = 5;

  // function codes of an input item
  localparam logic [2:0] FN_REG_WRITE  = 3'd0;
  localparam logic [2:0] FN_REG_PEEK   = 3'd1;
  localparam logic [2:0] FN_LOW_READ   = 3'd2;
  localparam logic [2:0] FN_LOW_WRITE  = 3'd3;
  localparam logic [2:0] FN_HIGH_READ  = 3'd4;
  localparam logic [2:0] FN_HIGH_WRITE = 3'd5;
  localparam logic [2:0] FN_ROM_LOAD   = 3'd6;

  localparam logic [7:0] BYTE_FF = 8'hFF;

  // where the result byte comes from
  typedef enum logic [2:0] {
    RSEL_ZERO,
    RSEL_PEEK,
    RSEL_ROM,
    RSEL_RAM,
    RSEL_FF
  } rsel_t;

  // memory port controls for one item
  typedef struct packed {
    logic rom_re;
    logic rom_we;
    logic ram_re;
    logic ram_we;
  } mem_ctl_t;

  // what travels with an item while its memory read is in flight
  typedef struct packed {
    rsel_t      rsel;
    logic [7:0] peek_data;
    logic       cart_enabled;
    logic       export_ram;
  } stage_t;

endpackage

FILE: rtl/brcm_ram.sv
// ----------------------------------------------------------------------------
// brcm_ram: generic single-port synchronous ram
// one access per cycle, registered read data held until the next read
// ----------------------------------------------------------------------------
module brcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/brcm_decode.sv
// ----------------------------------------------------------------------------
// brcm_decode: item decode
// turns one item and the bank state into memory controls, addresses,
// the next bank state and the record carried to the result stage
// ----------------------------------------------------------------------------
module brcm_decode
  import brcm_pkg::*;
#(
  parameter int RAM_BANKS     = RAM_BANKS_DEF,
  parameter int ROM_BANKS_MAX = ROM_BANKS_MAX_DEF
) (
  input  logic [2:0]                                      func,
  input  logic [HALF_OFFSET_W-1:0]                        window_offset,
  input  logic [7:0]                                      write_data,
  input  logic [ROM_LOAD_ADDR_W-1:0]                      rom_load_address,
  input  logic [5:0]                                      bank_select,
  input  logic                                            disable_flag,
  input  logic [COUNT_W-1:0]                              rom_bank_count,
  output mem_ctl_t                                        mem_ctl,
  output logic [$clog2(ROM_BANKS_MAX*BANK_BYTES)-1:0]     rom_addr,
  output logic [$clog2(RAM_BANKS*BANK_BYTES)-1:0]         ram_addr,
  output logic [5:0]                                      bank_next,
  output logic                                            disable_next,
  output stage_t                                          stage
);

  localparam int ROM_AW = $clog2(ROM_BANKS_MAX*BANK_BYTES);
  localparam int RAM_AW = $clog2(RAM_BANKS*BANK_BYTES);
  localparam logic [5:0] RAM_BANKS_W     = 6'(RAM_BANKS);
  localparam logic [4:0] ROM_BANKS_MAX_W = 5'(ROM_BANKS_MAX);

  logic [13:0] pos;
  logic [18:0] ram_full;
  logic [17:0] rom_full;
  logic        ram_ok;
  logic        rom_ok;
  logic        load_ok;

  assign pos      = {(func == FN_HIGH_READ) || (func == FN_HIGH_WRITE), window_offset};
  assign ram_full = {bank_select[4:0], pos};
  assign rom_full = {bank_select[3:0], pos};

  assign ram_ok  = !disable_flag && bank_select[5] && ({1'b0, bank_select[4:0]} < RAM_BANKS_W);
  assign rom_ok  = !disable_flag && !bank_select[5]
                   && ({1'b0, bank_select[3:0]} < rom_bank_count)
                   && ({1'b0, bank_select[3:0]} < ROM_BANKS_MAX_W);
  assign load_ok = {1'b0, rom_load_address[17:14]} < ROM_BANKS_MAX_W;

  assign ram_addr = ram_full[RAM_AW-1:0];
  assign rom_addr = (func == FN_ROM_LOAD) ? rom_load_address[ROM_AW-1:0]
                                          : rom_full[ROM_AW-1:0];

  always_comb begin
    mem_ctl         = '0;
    bank_next       = bank_select;
    disable_next    = disable_flag;
    stage.rsel      = RSEL_ZERO;
    stage.peek_data = {1'b0, disable_flag, 2'b00, bank_select[3:0]};
    case (func)
      FN_REG_WRITE: begin
        bank_next    = write_data[5:0];
        disable_next = write_data[6];
      end
      FN_REG_PEEK: begin
        stage.rsel = RSEL_PEEK;
      end
      FN_LOW_READ, FN_HIGH_READ: begin
        if (ram_ok) begin
          stage.rsel     = RSEL_RAM;
          mem_ctl.ram_re = 1'b1;
        end else if (rom_ok) begin
          stage.rsel     = RSEL_ROM;
          mem_ctl.rom_re = 1'b1;
        end else begin
          stage.rsel = RSEL_FF;
        end
      end
      FN_LOW_WRITE, FN_HIGH_WRITE: begin
        mem_ctl.ram_we = ram_ok;
      end
      FN_ROM_LOAD: begin
        mem_ctl.rom_we = load_ok;
      end
      default: begin
      end
    endcase
    // flags report the state after this item
    stage.cart_enabled = !disable_next;
    stage.export_ram   = !disable_next && bank_next[5];
  end

endmodule

FILE: rtl/banked_rom_ram_cartridge_mapper_core.sv
// ----------------------------------------------------------------------------
// banked_rom_ram_cartridge_mapper_core: bank-switching cartridge mapper
// 16 KB window onto banked rom or ram, with bank register, rom load port
// and a bank-count register
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_data (rom_bank_count)
//  in       | in_valid/in_stall    | func, window_offset, write_data,
//           |                      | rom_load_address
//  out      | out_valid/out_stall  | read_data, cart_enabled, export_ram
//
//  one item per cycle sustained while out_stall stays low; a result item is
//  presented from the output register, which loads from the read stage once
//  it is free (the rom/ram read happens at the accepting edge)
//  the rom and ram are single-port memories, at most one access per item
//  in_stall rises when the staged item cannot move into a held output
//  register; the read data stays in the memory output register meanwhile
//  reset clears the bank register, the disable bit, the bank count and all
//  valid flags; memory contents are left untouched, no clearing pass
// ----------------------------------------------------------------------------
module banked_rom_ram_cartridge_mapper_core
  import brcm_pkg::*;
#(
  parameter int RAM_BANKS     = RAM_BANKS_DEF,
  parameter int ROM_BANKS_MAX = ROM_BANKS_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [COUNT_W-1:0]         cfg_data,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 func,
  input  logic [HALF_OFFSET_W-1:0]   window_offset,
  input  logic [7:0]                 write_data,
  input  logic [ROM_LOAD_ADDR_W-1:0] rom_load_address,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 read_data,
  output logic                       cart_enabled,
  output logic                       export_ram
);

  localparam int ROM_DEPTH = ROM_BANKS_MAX * BANK_BYTES;
  localparam int RAM_DEPTH = RAM_BANKS * BANK_BYTES;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // mapper state
  logic [5:0]         bank_select;
  logic               disable_flag;
  logic [COUNT_W-1:0] rom_bank_count;

  // decode results
  mem_ctl_t          mem_ctl;
  logic [ROM_AW-1:0] rom_addr;
  logic [RAM_AW-1:0] ram_addr;
  logic [5:0]        bank_next;
  logic              disable_next;
  stage_t            stage_in;

  // read stage and memory outputs
  logic       stage_valid;
  stage_t     stage;
  logic [7:0] rom_rdata;
  logic [7:0] ram_rdata;
  logic [7:0] read_data_next;

  logic accept;
  logic advance;

  // handshake: the read stage moves on when the output register is free
  // or being emptied in the same cycle
  assign advance   = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  brcm_decode #(
    .RAM_BANKS     (RAM_BANKS),
    .ROM_BANKS_MAX (ROM_BANKS_MAX)
  ) u_decode (
    .func             (func),
    .window_offset    (window_offset),
    .write_data       (write_data),
    .rom_load_address (rom_load_address),
    .bank_select      (bank_select),
    .disable_flag     (disable_flag),
    .rom_bank_count   (rom_bank_count),
    .mem_ctl          (mem_ctl),
    .rom_addr         (rom_addr),
    .ram_addr         (ram_addr),
    .bank_next        (bank_next),
    .disable_next     (disable_next),
    .stage            (stage_in)
  );

  // memories are touched only at the accepting edge, so a stalled
  // read keeps its data in the memory output register
  brcm_ram #(
    .WIDTH (8),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk   (clk),
    .re    (accept && mem_ctl.rom_re),
    .we    (accept && mem_ctl.rom_we),
    .addr  (rom_addr),
    .wdata (write_data),
    .rdata (rom_rdata)
  );

  brcm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .re    (accept && mem_ctl.ram_re),
    .we    (accept && mem_ctl.ram_we),
    .addr  (ram_addr),
    .wdata (write_data),
    .rdata (ram_rdata)
  );

  // bank register and bank count
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select    <= '0;
      disable_flag   <= 1'b0;
      rom_bank_count <= '0;
    end else begin
      if (accept) begin
        bank_select  <= bank_next;
        disable_flag <= disable_next;
      end
      if (cfg_valid && cfg_ready) begin
        rom_bank_count <= cfg_data;
      end
    end
  end

  // read stage: item waits here for its memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept || (stage_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_in;
    end
  end

  // pick the result byte
  always_comb begin
    case (stage.rsel)
      RSEL_PEEK: read_data_next = stage.peek_data;
      RSEL_ROM:  read_data_next = rom_rdata;
      RSEL_RAM:  read_data_next = ram_rdata;
      RSEL_FF:   read_data_next = BYTE_FF;
      default:   read_data_next = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data    <= read_data_next;
      cart_enabled <= stage.cart_enabled;
      export_ram   <= stage.export_ram;
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the banked rom/ram cartridge mapper
// drives a short table of directed accesses, then phases of random bus
// traffic under several rom bank counts; every result item is checked against
// a hand-written reply or a bank-switching predictor kept in step with accepted items
// ----------------------------------------------------------------------------
module tb_top
  import brcm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // selector value with no function behind it
  localparam logic [2:0] FN_UNUSED = 3'd7;

  // nothing accepted on any channel for this long means the block hung;
  // the longest legal silence is the receiver hold-off
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int PHASE_ITEMS = 140;
  localparam int MARKS = 8;

  // one bus access as the sender offers it
  typedef struct packed {
    logic [2:0]                 fn;
    logic [HALF_OFFSET_W-1:0]   ofs;
    logic [7:0]                 wdata;
    logic [ROM_LOAD_ADDR_W-1:0] laddr;
  } bus_access_t;

  // one result item
  typedef struct packed {
    logic [7:0] rd;
    logic       en;
    logic       xram;
  } bus_reply_t;

  // directed row: a bank count write or an access, with an optional
  // hand-written reply
  typedef struct packed {
    logic                       cfg_row;
    logic [2:0]                 fn;
    logic [HALF_OFFSET_W-1:0]   ofs;
    logic [7:0]                 wdata;
    logic [ROM_LOAD_ADDR_W-1:0] laddr;
    logic                       chk;
    logic [7:0]                 rd;
    logic                       en;
    logic                       xram;
  } dir_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [COUNT_W-1:0]         cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [2:0]                 func;
  logic [HALF_OFFSET_W-1:0]   window_offset;
  logic [7:0]                 write_data;
  logic [ROM_LOAD_ADDR_W-1:0] rom_load_address;
  logic                       out_valid;
  logic                       out_stall;
  logic [7:0]                 read_data;
  logic                       cart_enabled;
  logic                       export_ram;

  banked_rom_ram_cartridge_mapper_core uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .window_offset    (window_offset),
    .write_data       (write_data),
    .rom_load_address (rom_load_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_data        (read_data),
    .cart_enabled     (cart_enabled),
    .export_ram       (export_ram)
  );

  // predictor copy of the mapper state
  logic [5:0]         bank_sel;
  logic               cart_off;
  logic [COUNT_W-1:0] rom_count;
  logic [7:0]         rom_img [0:262143];
  logic [7:0]         ram_img [0:524287];

  // offsets known to be written, per bank and window half, so that reads
  // never land on a byte nobody stored
  logic [HALF_OFFSET_W-1:0] rom_mark [0:31][0:MARKS-1];
  int                       rom_mark_n [0:31];
  logic [HALF_OFFSET_W-1:0] ram_mark [0:63][0:MARKS-1];
  int                       ram_mark_n [0:63];

  bus_reply_t expected_replies [$];
  bus_reply_t head_reply;
  int         mismatches;
  int         results_seen;
  int         quiet_cycles;
  int         burst_left;
  bit         held_off;

  // directed accesses; replies typed in where they follow straight from
  // the register value, the bank count and the bytes just stored
  dir_row_t directed_rows [0:28] = '{
    // after reset: rom bank 0 shown, bank count 0, so reads give ff
    '{1'b0, FN_REG_PEEK,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b0},
    '{1'b0, FN_LOW_READ,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'hFF, 1'b1, 1'b0},
    '{1'b1, FN_REG_WRITE,  13'h0000, 8'd16, 18'h00000, 1'b0, 8'h00, 1'b0, 1'b0},
    // rom loads at both ends of the store
    '{1'b0, FN_ROM_LOAD,   13'h0000, 8'hA5, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b0},
    '{1'b0, FN_ROM_LOAD,   13'h0000, 8'h5A, 18'h3FFFF, 1'b1, 8'h00, 1'b1, 1'b0},
    '{1'b0, FN_LOW_READ,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'hA5, 1'b1, 1'b0},
    // bit 7 of a register write is dropped; rom bank 15
    '{1'b0, FN_REG_WRITE,  13'h0000, 8'h8F, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b0},
    '{1'b0, FN_HIGH_READ,  13'h1FFF, 8'h00, 18'h00000, 1'b1, 8'h5A, 1'b1, 1'b0},
    // write while rom is shown goes nowhere
    '{1'b0, FN_HIGH_WRITE, 13'h1FFF, 8'h00, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b0},
    '{1'b0, FN_HIGH_READ,  13'h1FFF, 8'h00, 18'h00000, 1'b1, 8'h5A, 1'b1, 1'b0},
    // ram bank 31; peek hides bit 5
    '{1'b0, FN_REG_WRITE,  13'h0000, 8'h3F, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b1},
    '{1'b0, FN_REG_PEEK,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'h0F, 1'b1, 1'b1},
    '{1'b0, FN_LOW_WRITE,  13'h0000, 8'hFF, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b1},
    '{1'b0, FN_HIGH_WRITE, 13'h1FFF, 8'h00, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b1},
    '{1'b0, FN_LOW_READ,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'hFF, 1'b1, 1'b1},
    '{1'b0, FN_HIGH_READ,  13'h1FFF, 8'h00, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b1},
    // cartridge disabled: reads give ff, writes dropped, loads still work
    '{1'b0, FN_REG_WRITE,  13'h0000, 8'h7F, 18'h00000, 1'b1, 8'h00, 1'b0, 1'b0},
    '{1'b0, FN_LOW_READ,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'hFF, 1'b0, 1'b0},
    '{1'b0, FN_HIGH_WRITE, 13'h1FFF, 8'h12, 18'h00000, 1'b1, 8'h00, 1'b0, 1'b0},
    '{1'b0, FN_REG_PEEK,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'h4F, 1'b0, 1'b0},
    '{1'b0, FN_ROM_LOAD,   13'h0000, 8'h99, 18'h08000, 1'b1, 8'h00, 1'b0, 1'b0},
    '{1'b0, FN_UNUSED,     13'h1FFF, 8'hFF, 18'h3FFFF, 1'b0, 8'h00, 1'b0, 1'b0},
    // rom bank at the count reads ff, just below it reads the byte
    '{1'b1, FN_REG_WRITE,  13'h0000, 8'd2,  18'h00000, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, FN_REG_WRITE,  13'h0000, 8'h02, 18'h00000, 1'b1, 8'h00, 1'b1, 1'b0},
    '{1'b0, FN_LOW_READ,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'hFF, 1'b1, 1'b0},
    '{1'b1, FN_REG_WRITE,  13'h0000, 8'd3,  18'h00000, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, FN_LOW_READ,   13'h0000, 8'h00, 18'h00000, 1'b1, 8'h99, 1'b1, 1'b0},
    // back to ram bank 31: the write made while disabled must not show
    '{1'b0, FN_REG_WRITE,  13'h0000, 8'hBF, 18'h00000, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, FN_HIGH_READ,  13'h1FFF, 8'h00, 18'h00000, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // apply one accepted access to the predictor state and work out its reply
  function automatic bus_reply_t predict_bus_reply(input bus_access_t acc);
    bus_reply_t r;
    logic       half;
    logic [5:0] key;
    r.rd = 8'h00;
    half = (acc.fn == FN_HIGH_READ) || (acc.fn == FN_HIGH_WRITE);
    case (acc.fn)
      FN_REG_WRITE: begin
        bank_sel = acc.wdata[5:0];
        cart_off = acc.wdata[6];
      end
      FN_REG_PEEK: r.rd = {1'b0, cart_off, 2'b00, bank_sel[3:0]};
      FN_LOW_READ, FN_HIGH_READ: begin
        if (cart_off) r.rd = BYTE_FF;
        else if (bank_sel[5]) r.rd = ram_img[{bank_sel[4:0], half, acc.ofs}];
        else if ({1'b0, bank_sel[3:0]} >= rom_count) r.rd = BYTE_FF;
        else r.rd = rom_img[{bank_sel[3:0], half, acc.ofs}];
      end
      FN_LOW_WRITE, FN_HIGH_WRITE: begin
        // only an enabled ram window takes writes; 5-bit index is always in range
        if (!cart_off && bank_sel[5]) begin
          ram_img[{bank_sel[4:0], half, acc.ofs}] = acc.wdata;
          key = {bank_sel[4:0], half};
          ram_mark[key][ram_mark_n[key] % MARKS] = acc.ofs;
          ram_mark_n[key]++;
        end
      end
      FN_ROM_LOAD: begin
        // an 18-bit address never leaves the 16-bank store
        rom_img[acc.laddr] = acc.wdata;
        key = {1'b0, acc.laddr[17:13]};
        rom_mark[key[4:0]][rom_mark_n[key[4:0]] % MARKS] = acc.laddr[12:0];
        rom_mark_n[key[4:0]]++;
      end
      default: ;
    endcase
    r.en = !cart_off;
    r.xram = !cart_off && bank_sel[5];
    return r;
  endfunction

  // offer one item in the sender's burst pattern, hold it until accepted
  task automatic issue(input bus_access_t acc, input logic typed, input bus_reply_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid         <= 1'b1;
    func             <= acc.fn;
    window_offset    <= acc.ofs;
    write_data       <= acc.wdata;
    rom_load_address <= acc.laddr;
    do @(posedge clk); while (in_stall);
    want = typed ? want : predict_bus_reply(acc);
    if (typed) void'(predict_bus_reply(acc));
    expected_replies.push_back(want);
  endtask

  // drain the block, let the pipeline settle, then write the bank count
  task automatic set_bank_count(input logic [COUNT_W-1:0] n);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    rom_count = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  // receiver: stall pattern in spans of random mode, plus one long hold-off
  // once traffic is well under way so the block backs up into its input
  initial begin : rx_side
    int mode;
    int span;
    int k;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        if (!held_off && results_seen >= 200) begin
          held_off = 1'b1;
          repeat (HOLD_OFF_CYCLES) begin
            out_stall <= 1'b1;
            @(negedge clk);
          end
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (k % 2 == 1);
        endcase
      end
    end
  end

  // result checking and hang watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: rd=%02h en=%0b ram=%0b", read_data, cart_enabled,
                     export_ram);
        end else begin
          head_reply = expected_replies.pop_front();
          if (read_data !== head_reply.rd || cart_enabled !== head_reply.en ||
              export_ram !== head_reply.xram) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected rd=%02h en=%0b ram=%0b, got rd=%02h en=%0b ram=%0b",
                       head_reply.rd, head_reply.en, head_reply.xram, read_data, cart_enabled,
                       export_ram);
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item accepted for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stim
    bus_access_t        acc;
    bus_reply_t         want;
    logic [COUNT_W-1:0] plan [0:6];
    logic               half;
    logic               live;
    logic [4:0]         romk;
    logic [5:0]         ramk;
    int                 ph;
    int                 n;
    int                 roll;
    int                 lim;
    int                 marks;
    int                 pick;

    rst              = 1'b1;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    func             = FN_REG_PEEK;
    window_offset    = '0;
    write_data       = '0;
    rom_load_address = '0;
    bank_sel         = '0;
    cart_off         = 1'b0;
    rom_count        = '0;
    mismatches       = 0;
    results_seen     = 0;
    quiet_cycles     = 0;
    burst_left       = 0;
    held_off         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_row) begin
        set_bank_count(directed_rows[i].wdata[COUNT_W-1:0]);
      end else begin
        acc.fn    = directed_rows[i].fn;
        acc.ofs   = directed_rows[i].ofs;
        acc.wdata = directed_rows[i].wdata;
        acc.laddr = directed_rows[i].laddr;
        want.rd   = directed_rows[i].rd;
        want.en   = directed_rows[i].en;
        want.xram = directed_rows[i].xram;
        issue(acc, directed_rows[i].chk, want);
      end
    end

    // random phases, each under its own bank count, extremes included
    plan = '{5'd16, 5'd0, 5'd31, 5'd7, 5'd1, 5'd16, 5'd0};
    plan[6] = COUNT_W'($urandom_range(0, 16));
    for (ph = 0; ph < 7; ph++) begin
      set_bank_count(plan[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        acc.ofs   = HALF_OFFSET_W'($urandom);
        acc.wdata = 8'($urandom);
        acc.laddr = ROM_LOAD_ADDR_W'($urandom);
        if ($urandom_range(0, 7) == 0) acc.ofs = $urandom_range(0, 1) ? 13'h1FFF : 13'h0000;
        half = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        lim  = (rom_count > 16) ? 16 : rom_count;
        // does a read right now reach a real memory byte
        live = !cart_off && (bank_sel[5] || {1'b0, bank_sel[3:0]} < rom_count);
        romk = {bank_sel[3:0], half};
        ramk = {bank_sel[4:0], half};
        if (roll < 10) begin
          // bank switch: mostly enabled, rom banks mostly inside the count
          acc.fn = FN_REG_WRITE;
          acc.wdata[6] = ($urandom_range(0, 9) == 0);
          if (!acc.wdata[5] && lim > 0 && $urandom_range(0, 1))
            acc.wdata[3:0] = 4'($urandom_range(0, lim - 1));
        end else if (roll < 16) begin
          acc.fn = FN_REG_PEEK;
        end else if (roll < 28) begin
          acc.fn = FN_ROM_LOAD;
          if ($urandom_range(0, 1)) acc.laddr[17:14] = bank_sel[3:0];
        end else if (roll < 44) begin
          acc.fn = half ? FN_HIGH_WRITE : FN_LOW_WRITE;
        end else if (roll < 94) begin
          acc.fn = half ? FN_HIGH_READ : FN_LOW_READ;
          if (live) begin
            marks = bank_sel[5] ? ram_mark_n[ramk] : rom_mark_n[romk];
            if (marks == 0 || $urandom_range(0, 4) == 0) begin
              // store a byte first, the read comes back to it later
              if (bank_sel[5]) begin
                acc.fn = half ? FN_HIGH_WRITE : FN_LOW_WRITE;
              end else begin
                acc.fn = FN_ROM_LOAD;
                acc.laddr = {bank_sel[3:0], half, acc.ofs};
              end
            end else begin
              pick = $urandom_range(0, ((marks > MARKS) ? MARKS : marks) - 1);
              acc.ofs = bank_sel[5] ? ram_mark[ramk][pick] : rom_mark[romk][pick];
            end
          end
        end else begin
          acc.fn = FN_UNUSED;
        end
        want = '0;
        issue(acc, 1'b0, want);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
rtl/brcm_pkg.sv
rtl/brcm_ram.sv
rtl/brcm_decode.sv
rtl/banked_rom_ram_cartridge_mapper_core.sv
tb/tb_top.sv
